>>> design/e2r_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package e2r_pkg;

  // field widths
  localparam int ENTRY_W  = 16;
  localparam int NT_W     = 18;
  localparam int DET_W    = 33;
  localparam int LAMBDA_W = 18;

  // front arithmetic
  localparam int PROD_W      = 2 * ENTRY_W;
  localparam int SUM_W       = ENTRY_W + 1;
  localparam int SQR_W       = 2 * SUM_W;
  localparam int DISC_FULL_W = DET_W + 3;

  // square root: non-negative discriminant stays below 2^33
  localparam int DISC_W = 33;
  localparam int ROOT_W = (DISC_W + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int REM_W  = ROOT_W + 2;

  // eigenvalue sums before halving
  localparam int LSUM_W = LAMBDA_W + 2;

  // decoupling queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic signed [LAMBDA_W-1:0] LAMBDA_MAX = {1'b0, {(LAMBDA_W-1){1'b1}}};
  localparam logic signed [LAMBDA_W-1:0] LAMBDA_MIN = {1'b1, {(LAMBDA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ROOTS_NONE = 2'd0,
    ROOTS_ONE  = 2'd1,
    ROOTS_TWO  = 2'd2
  } roots_t;

  typedef struct packed {
    logic signed [NT_W-1:0]  neg_trace;
    logic signed [DET_W-1:0] det_value;
    roots_t                  root_count;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic [DISC_W-1:0]  disc;
  } item_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  // one restoring square root step: bring in two radicand bits, decide one root bit
  function automatic sq_t sqrt_step(input logic [REM_W-1:0] rem,
                                    input logic [ROOT_W-1:0] root,
                                    input logic [1:0] pair);
    logic [REM_W-1:0] acc;
    logic [REM_W-1:0] trial;
    sq_t              res;
    acc   = {rem[REM_W-3:0], pair};
    trial = {root, 2'b01};
    if (acc >= trial) begin
      res.rem  = acc - trial;
      res.root = {root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = acc;
      res.root = {root[ROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

  // clamp a halved sum to the eigenvalue range
  function automatic logic signed [LAMBDA_W-1:0] sat_lambda(input logic signed [LSUM_W-1:0] v);
    logic signed [LAMBDA_W-1:0] res;
    if (v > LSUM_W'(LAMBDA_MAX)) begin
      res = LAMBDA_MAX;
    end else if (v < LSUM_W'(LAMBDA_MIN)) begin
      res = LAMBDA_MIN;
    end else begin
      res = LAMBDA_W'(v);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> design/eigen_2x2_real_core.sv
// real eigenvalues of a 2x2 matrix of signed q8.8 entries
//
// input channel: in_valid / in_stall with the four entries in_entry_rc, one
//   matrix per item; an item is taken at a clock edge with in_valid high and
//   in_stall low
// result channel: out_valid / out_stall with minus the trace (q8.8), the
//   determinant (q16.16), the root count and the eigenvalues, larger first;
//   eigenvalue fields that do not apply read zero
// throughput: one item per cycle while in_stall stays low; the block takes a
//   new matrix every such cycle while earlier ones are still in flight
// path from acceptance to out_valid: 3 front stages (products, determinant
//   and trace square, discriminant), a queue slot, 17 square root stages
//   (one root bit each), one output register
// stalls: a held output freezes the back pipe only; the 4-item queue lets the
//   front keep taking items until it fills, then in_stall rises
// reset: synchronous, active low; all in-flight items are dropped and both
//   channels come up empty with in_stall low
`timescale 1ns / 1ps
`default_nettype none
module eigen_2x2_real_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // matrix in
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [e2r_pkg::ENTRY_W-1:0]  in_entry_00,
  input  wire logic signed [e2r_pkg::ENTRY_W-1:0]  in_entry_01,
  input  wire logic signed [e2r_pkg::ENTRY_W-1:0]  in_entry_10,
  input  wire logic signed [e2r_pkg::ENTRY_W-1:0]  in_entry_11,
  // results out
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [e2r_pkg::NT_W-1:0]          out_neg_trace,
  output logic signed [e2r_pkg::DET_W-1:0]         out_det_value,
  output logic [1:0]                               out_root_count,
  output logic signed [e2r_pkg::LAMBDA_W-1:0]      out_lambda_high,
  output logic signed [e2r_pkg::LAMBDA_W-1:0]      out_lambda_low
);

  // front to queue
  logic            push;
  logic            q_full;
  e2r_pkg::item_t  push_item;

  // queue to back
  logic            q_valid;
  logic            q_pop;
  e2r_pkg::item_t  q_item;

  // front: coefficients, discriminant and root count
  e2r_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_entry_00 (in_entry_00),
    .in_entry_01 (in_entry_01),
    .in_entry_10 (in_entry_10),
    .in_entry_11 (in_entry_11),
    .q_full      (q_full),
    .push        (push),
    .push_item   (push_item)
  );

  // short queue so front and back stall independently
  e2r_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_item)
  );

  // back: pipelined square root, eigenvalues, output register
  e2r_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_neg_trace   (out_neg_trace),
    .out_det_value   (out_det_value),
    .out_root_count  (out_root_count),
    .out_lambda_high (out_lambda_high),
    .out_lambda_low  (out_lambda_low)
  );

`ifndef SYNTHESIS
  // no real roots: both eigenvalue fields zero
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_count == e2r_pkg::ROOTS_NONE
      |-> out_lambda_high == '0 && out_lambda_low == '0)
    else $error("eigenvalues not zero with no real roots");

  // single root: smaller field zero
  a_one_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_count == e2r_pkg::ROOTS_ONE |-> out_lambda_low == '0)
    else $error("lambda_low not zero with one root");

  // two roots come out ordered
  a_two_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_count == e2r_pkg::ROOTS_TWO
      |-> out_lambda_high >= out_lambda_low)
    else $error("eigenvalues out of order");

  // root count is always a defined code
  a_count_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_root_count == e2r_pkg::ROOTS_NONE
               || out_root_count == e2r_pkg::ROOTS_ONE
               || out_root_count == e2r_pkg::ROOTS_TWO)
    else $error("undefined root count");
`endif

endmodule
`default_nettype wire

>>> design/e2r_front.sv
`timescale 1ns / 1ps
`default_nettype none
module e2r_front (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic signed [e2r_pkg::ENTRY_W-1:0] in_entry_00,
  input  wire logic signed [e2r_pkg::ENTRY_W-1:0] in_entry_01,
  input  wire logic signed [e2r_pkg::ENTRY_W-1:0] in_entry_10,
  input  wire logic signed [e2r_pkg::ENTRY_W-1:0] in_entry_11,
  input  wire logic                               q_full,
  output logic                                    push,
  output e2r_pkg::item_t                          push_item
);

  logic en;

  logic                                    v1_r;
  logic signed [e2r_pkg::PROD_W-1:0]       p0_r;
  logic signed [e2r_pkg::PROD_W-1:0]       p1_r;
  logic signed [e2r_pkg::SUM_W-1:0]        sum_r;

  logic                                    v2_r;
  logic signed [e2r_pkg::DET_W-1:0]        det_r;
  logic signed [e2r_pkg::NT_W-1:0]         nt_r;
  logic signed [e2r_pkg::SQR_W-1:0]        sqr_r;

  logic                                    v3_r;
  e2r_pkg::item_t                          item_r;
  e2r_pkg::item_t                          item_nxt;
  logic signed [e2r_pkg::DISC_FULL_W-1:0]  disc_full;

  assign en       = !(v3_r && q_full);
  assign in_stall = !en;
  assign push      = v3_r && !q_full;
  assign push_item = item_r;

  // products and trace
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_r  <= in_entry_00 * in_entry_11;
      p1_r  <= in_entry_01 * in_entry_10;
      sum_r <= e2r_pkg::SUM_W'(in_entry_00) + e2r_pkg::SUM_W'(in_entry_11);
    end
  end

  // determinant, minus trace, trace squared
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det_r <= e2r_pkg::DET_W'(p0_r) - e2r_pkg::DET_W'(p1_r);
      nt_r  <= -e2r_pkg::NT_W'(sum_r);
      sqr_r <= sum_r * sum_r;
    end
  end

  // discriminant and root count
  always_comb begin
    disc_full = e2r_pkg::DISC_FULL_W'(sqr_r) - (e2r_pkg::DISC_FULL_W'(det_r) <<< 2);
    item_nxt.side.neg_trace = nt_r;
    item_nxt.side.det_value = det_r;
    item_nxt.disc           = '0;
    if (disc_full[e2r_pkg::DISC_FULL_W-1]) begin
      item_nxt.side.root_count = e2r_pkg::ROOTS_NONE;
    end else if (disc_full == '0) begin
      item_nxt.side.root_count = e2r_pkg::ROOTS_ONE;
    end else begin
      item_nxt.side.root_count = e2r_pkg::ROOTS_TWO;
      item_nxt.disc            = disc_full[e2r_pkg::DISC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r <= item_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/e2r_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module e2r_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire e2r_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output e2r_pkg::item_t      head_item
);

  logic [e2r_pkg::QPTR_W-1:0] wr_r;
  logic [e2r_pkg::QPTR_W-1:0] rd_r;
  logic [e2r_pkg::QPTR_W:0]   cnt_r;
  logic [e2r_pkg::QPTR_W:0]   cnt_nxt;
  e2r_pkg::item_t             slot_r [e2r_pkg::QUEUE_DEPTH];

  assign full       = cnt_r == (e2r_pkg::QPTR_W + 1)'(e2r_pkg::QUEUE_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_item  = slot_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

>>> design/e2r_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none
module e2r_isqrt (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire e2r_pkg::item_t                in_item,
  output logic                               out_valid,
  output e2r_pkg::side_t                     out_side,
  output logic [e2r_pkg::ROOT_W-1:0]         out_root
);

  localparam int NSTAGE = e2r_pkg::ROOT_W;

  logic                        vld_r  [NSTAGE];
  e2r_pkg::sq_t                sq_r   [NSTAGE];
  logic [e2r_pkg::RAD_W-1:0]   rad_r  [NSTAGE];
  e2r_pkg::side_t              side_r [NSTAGE];

  // one root bit per stage, most significant first
  for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
    logic                          vld_in;
    logic [e2r_pkg::REM_W-1:0]     rem_in;
    logic [e2r_pkg::ROOT_W-1:0]    root_in;
    logic [e2r_pkg::RAD_W-1:0]     rad_in;
    e2r_pkg::side_t                side_in;
    e2r_pkg::sq_t                  sq_nxt;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = e2r_pkg::RAD_W'(in_item.disc);
      assign side_in = in_item.side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = sq_r[k-1].rem;
      assign root_in = sq_r[k-1].root;
      assign rad_in  = rad_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign sq_nxt = e2r_pkg::sqrt_step(rem_in, root_in, rad_in[e2r_pkg::RAD_W-1-2*k -: 2]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k]   <= sq_nxt;
        rad_r[k]  <= rad_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[NSTAGE-1];
  assign out_side  = side_r[NSTAGE-1];
  assign out_root  = sq_r[NSTAGE-1].root;

endmodule
`default_nettype wire

>>> design/e2r_back.sv
`timescale 1ns / 1ps
`default_nettype none
module e2r_back (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                q_valid,
  input  wire e2r_pkg::item_t                      q_item,
  output logic                                     q_pop,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [e2r_pkg::NT_W-1:0]          out_neg_trace,
  output logic signed [e2r_pkg::DET_W-1:0]         out_det_value,
  output logic [1:0]                               out_root_count,
  output logic signed [e2r_pkg::LAMBDA_W-1:0]      out_lambda_high,
  output logic signed [e2r_pkg::LAMBDA_W-1:0]      out_lambda_low
);

  logic                                  en;
  logic                                  sq_valid;
  e2r_pkg::side_t                        sq_side;
  logic [e2r_pkg::ROOT_W-1:0]            sq_root;

  logic signed [e2r_pkg::LSUM_W-1:0]     nb;
  logic signed [e2r_pkg::LSUM_W-1:0]     sroot;
  logic signed [e2r_pkg::LSUM_W-1:0]     hi_sum;
  logic signed [e2r_pkg::LSUM_W-1:0]     lo_sum;
  logic signed [e2r_pkg::LAMBDA_W-1:0]   hi_nxt;
  logic signed [e2r_pkg::LAMBDA_W-1:0]   lo_nxt;

  logic                                  out_valid_r;
  logic signed [e2r_pkg::NT_W-1:0]       nt_r;
  logic signed [e2r_pkg::DET_W-1:0]      det_r;
  logic [1:0]                            cnt_r;
  logic signed [e2r_pkg::LAMBDA_W-1:0]   hi_r;
  logic signed [e2r_pkg::LAMBDA_W-1:0]   lo_r;

  // whole back pipe moves unless the output register is held
  assign en    = !out_valid_r || !out_stall;
  assign q_pop = en && q_valid;

  e2r_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (q_valid),
    .in_item   (q_item),
    .out_valid (sq_valid),
    .out_side  (sq_side),
    .out_root  (sq_root)
  );

  always_comb begin
    nb     = -e2r_pkg::LSUM_W'(sq_side.neg_trace);
    sroot  = $signed({{(e2r_pkg::LSUM_W-e2r_pkg::ROOT_W){1'b0}}, sq_root});
    hi_sum = nb + sroot;
    lo_sum = nb - sroot;
    hi_nxt = '0;
    lo_nxt = '0;
    case (sq_side.root_count)
      e2r_pkg::ROOTS_TWO: begin
        hi_nxt = e2r_pkg::sat_lambda(hi_sum >>> 1);
        lo_nxt = e2r_pkg::sat_lambda(lo_sum >>> 1);
      end
      e2r_pkg::ROOTS_ONE: begin
        hi_nxt = e2r_pkg::sat_lambda(nb >>> 1);
      end
      default: begin
        hi_nxt = '0;
        lo_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nt_r  <= sq_side.neg_trace;
      det_r <= sq_side.det_value;
      cnt_r <= sq_side.root_count;
      hi_r  <= hi_nxt;
      lo_r  <= lo_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_neg_trace   = nt_r;
  assign out_det_value   = det_r;
  assign out_root_count  = cnt_r;
  assign out_lambda_high = hi_r;
  assign out_lambda_low  = lo_r;

endmodule
`default_nettype wire
